### rtl/wsd_pkg.sv
// shared types and constants for the work-stealing deque scheduler
package wsd_pkg;

    localparam int CORES       = 4;
    localparam int DEPTH       = 128;
    localparam int CORE_W      = 2;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int ADDR_W      = CORE_W + IDX_W;
    localparam int MEM_DEPTH   = CORES * DEPTH;
    localparam int PID_W       = 16;
    localparam int WEIGHT_W    = 8;
    localparam int QCNT_W      = 7;
    localparam int TAKEN_W     = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_FIFO_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] MODE_ENQ_BACK  = 2'd0;
    localparam logic [1:0] MODE_ENQ_FRONT = 2'd1;
    localparam logic [1:0] MODE_TAKE      = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef struct packed {
        logic [PID_W-1:0]    pid;
        logic [WEIGHT_W-1:0] weight;
    } job_t;

    typedef struct packed {
        logic [1:0]          mode;
        logic [CORE_W-1:0]   core;
        logic [PID_W-1:0]    new_pid;
        logic [WEIGHT_W-1:0] new_weight;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [PID_W-1:0]    job_pid;
        logic [WEIGHT_W-1:0] job_weight;
        logic [CORE_W-1:0]   from_core;
        logic                stolen;
        logic [QCNT_W-1:0]   queue_count;
        logic [TAKEN_W-1:0]  taken_count;
    } rsp_t;

    // one store access plus the answer fields worked out by the front end
    typedef struct packed {
        logic               wr;
        logic               rd;
        addr_t              addr;
        job_t               data;
        status_t            status;
        logic [CORE_W-1:0]  from_core;
        logic               stolen;
        logic [QCNT_W-1:0]  queue_count;
        logic [TAKEN_W-1:0] taken_count;
    } op_t;

endpackage

### rtl/wsd_front.sv
// front end: ring pointers, completed-job counts, steal pick and request classification
module wsd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  wsd_pkg::req_t req,
    output logic          push_valid,
    input  logic          push_ready,
    output wsd_pkg::op_t  push_op
);
    import wsd_pkg::*;

    idx_t               head_reg  [CORES];
    idx_t               tail_reg  [CORES];
    logic [TAKEN_W-1:0] done_reg  [CORES];
    idx_t               head_next [CORES];
    idx_t               tail_next [CORES];
    logic [TAKEN_W-1:0] done_next [CORES];

    logic [CORES-1:0]  empty_vec;
    logic              found;
    logic [CORE_W-1:0] pick_idx;
    logic              core_ok;
    logic              accept;
    idx_t              head_c;
    idx_t              tail_c;
    logic              full_c;
    op_t               op;

    assign req_ready  = push_ready;
    assign accept     = req_valid && push_ready;
    assign push_valid = req_valid;
    assign push_op    = op;
    assign core_ok    = ({1'b0, req.core} < (CORE_W + 1)'(CORES));

    always_comb
    begin
        for (int i = 0; i < CORES; i++)
        begin
            empty_vec[i] = (head_reg[i] == tail_reg[i]);
        end
        // lowest-numbered non-empty deque
        found    = 1'b0;
        pick_idx = '0;
        for (int i = 0; i < CORES; i++)
        begin
            if (!found && !empty_vec[i])
            begin
                found    = 1'b1;
                pick_idx = CORE_W'(i);
            end
        end
    end

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        done_next = done_reg;
        head_c    = head_reg[req.core];
        tail_c    = tail_reg[req.core];
        full_c    = (head_c == tail_c + idx_t'(1));
        op        = '0;
        op.status = ST_OK;
        if (!core_ok)
        begin
            op.status = (req.mode == MODE_ENQ_BACK || req.mode == MODE_ENQ_FRONT)
                        ? ST_FULL : ST_EMPTY;
        end
        else
        begin
            unique case (req.mode)
                MODE_ENQ_BACK:
                begin
                    if (full_c)
                    begin
                        op.status = ST_FULL;
                    end
                    else
                    begin
                        tail_next[req.core] = tail_c + idx_t'(1);
                        op.wr   = 1'b1;
                        op.addr = {req.core, tail_c + idx_t'(1)};
                    end
                end
                MODE_ENQ_FRONT:
                begin
                    if (full_c)
                    begin
                        op.status = ST_FULL;
                    end
                    else
                    begin
                        head_next[req.core] = head_c - idx_t'(1);
                        op.wr   = 1'b1;
                        op.addr = {req.core, head_c};
                    end
                end
                default:
                begin
                    if (!empty_vec[req.core])
                    begin
                        head_next[req.core] = head_c + idx_t'(1);
                        done_next[req.core] = done_reg[req.core] + TAKEN_W'(1);
                        op.rd        = 1'b1;
                        op.addr      = {req.core, head_c + idx_t'(1)};
                        op.from_core = req.core;
                    end
                    else if (found)
                    begin
                        tail_next[pick_idx] = tail_reg[pick_idx] - idx_t'(1);
                        done_next[req.core] = done_reg[req.core] + TAKEN_W'(1);
                        op.rd        = 1'b1;
                        op.addr      = {pick_idx, tail_reg[pick_idx]};
                        op.from_core = pick_idx;
                        op.stolen    = 1'b1;
                    end
                    else
                    begin
                        op.status = ST_EMPTY;
                    end
                end
            endcase
            op.queue_count = QCNT_W'(tail_next[req.core] - head_next[req.core]);
            op.taken_count = done_next[req.core];
        end
        op.data.pid    = req.new_pid;
        op.data.weight = req.new_weight;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CORES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                done_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            done_reg <= done_next;
        end
    end

endmodule

### rtl/wsd_queue.sv
// short in-order queue of store operations between front and back ends
module wsd_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  wsd_pkg::op_t push_op,
    output logic         pop_valid,
    input  logic         pop_ready,
    output wsd_pkg::op_t pop_op
);
    import wsd_pkg::*;

    op_t                    slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]      wr_ptr_reg;
    logic [QPTR_W-1:0]      rd_ptr_reg;
    logic [QCNT_FIFO_W-1:0] count_reg;
    logic [QCNT_FIFO_W-1:0] count_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg < QCNT_FIFO_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_FIFO_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_FIFO_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == QUEUE_DEPTH - 1)
                              ? '0 : wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == QUEUE_DEPTH - 1)
                              ? '0 : rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

### rtl/wsd_back.sv
// back end: job store access and registered answer
module wsd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  wsd_pkg::op_t  pop_op,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output wsd_pkg::rsp_t rsp
);
    import wsd_pkg::*;

    job_t job_mem [MEM_DEPTH];
    job_t rd_data_reg;
    op_t  s1_op_reg;
    logic s1_valid_reg;
    logic s1_valid_next;
    logic issue;

    assign pop_ready = !s1_valid_reg || rsp_ready;
    assign issue     = pop_valid && pop_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (issue)
        begin
            s1_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            if (pop_op.wr)
            begin
                job_mem[pop_op.addr] <= pop_op.data;
            end
            rd_data_reg <= job_mem[pop_op.addr];
            s1_op_reg   <= pop_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    assign rsp_valid        = s1_valid_reg;
    assign rsp.status       = s1_op_reg.status;
    assign rsp.job_pid      = s1_op_reg.rd ? rd_data_reg.pid : '0;
    assign rsp.job_weight   = s1_op_reg.rd ? rd_data_reg.weight : '0;
    assign rsp.from_core    = s1_op_reg.from_core;
    assign rsp.stolen       = s1_op_reg.stolen;
    assign rsp.queue_count  = s1_op_reg.queue_count;
    assign rsp.taken_count  = s1_op_reg.taken_count;

endmodule

### rtl/work_stealing_deque_scheduler.sv
// top level of the work-stealing deque scheduler
// the answer is registered: an accepted request passes a queue slot, then the answer register
// throughput: one request per cycle while answers are taken; each request makes one job-store access
// a two-entry queue separates pointer update from store access and answer register
// reset: rst_n clears ring pointers, completed-job counts and queue; store is not cleared
module work_stealing_deque_scheduler (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  wsd_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output wsd_pkg::rsp_t rsp
);
    import wsd_pkg::*;

    logic push_valid;
    logic push_ready;
    op_t  push_op;
    logic pop_valid;
    logic pop_ready;
    op_t  pop_op;

    wsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op)
    );

    wsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    wsd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

endmodule

### rtl/wsd_checker.sv
// port-level checks for the work-stealing deque scheduler
module wsd_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input wsd_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input wsd_pkg::rsp_t rsp
);
    import wsd_pkg::*;

    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
        else $error("request changed while stalled");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("answer changed while stalled");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |->
            rsp.job_pid == '0 && rsp.job_weight == '0 && rsp.from_core == '0 && !rsp.stolen)
        else $error("failed request carries a job");

    a_steal_own_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.stolen |-> rsp.status == ST_OK && rsp.queue_count == '0)
        else $error("steal while own deque not empty");

    a_none_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_EMPTY |-> rsp.queue_count == '0)
        else $error("no job reported but own deque holds jobs");

endmodule

bind work_stealing_deque_scheduler wsd_checker u_wsd_checker (.*);

### tb/testbench.sv
// self-checking testbench for the work-stealing deque scheduler
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wsd_pkg::*;

    localparam logic [1:0] MODE_TAKE_ALT = 2'd3;
    localparam int QUIET_LIMIT = 3000;

    typedef struct {
        req_t r;
        bit   wait_idle;
    } request_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    request_item_t request_queue[$];
    rsp_t expected_answers[$];

    job_t jobs_held[CORES][DEPTH];
    idx_t ring_head[CORES];
    idx_t ring_tail[CORES];
    logic [TAKEN_W-1:0] jobs_taken[CORES];

    int req_gap = 0;
    int requests_sent = 0;
    int rsp_pause = 0;
    int rsp_stall = 0;
    int answers_seen = 0;
    int quiet_cycles = 0;
    int mismatches = 0;

    work_stealing_deque_scheduler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #4 clk = ~clk;

    function automatic rsp_t schedule_step(req_t r);
        rsp_t a;
        int c;
        int v;
        bit found;
        a = '0;
        a.status = ST_OK;
        c = r.core;
        if (r.mode == MODE_ENQ_BACK || r.mode == MODE_ENQ_FRONT)
        begin
            if (ring_head[c] == idx_t'(ring_tail[c] + 1))
                a.status = ST_FULL;
            else if (r.mode == MODE_ENQ_BACK)
            begin
                ring_tail[c] = ring_tail[c] + idx_t'(1);
                jobs_held[c][ring_tail[c]] = {r.new_pid, r.new_weight};
            end
            else
            begin
                jobs_held[c][ring_head[c]] = {r.new_pid, r.new_weight};
                ring_head[c] = ring_head[c] - idx_t'(1);
            end
        end
        else if (ring_head[c] != ring_tail[c])
        begin
            ring_head[c] = ring_head[c] + idx_t'(1);
            {a.job_pid, a.job_weight} = jobs_held[c][ring_head[c]];
            a.from_core = c[CORE_W-1:0];
            jobs_taken[c] = jobs_taken[c] + TAKEN_W'(1);
        end
        else
        begin
            // steal from the back of the lowest-numbered non-empty ring
            found = 1'b0;
            for (v = 0; v < CORES; v++)
            begin
                if (!found && ring_head[v] != ring_tail[v])
                begin
                    {a.job_pid, a.job_weight} = jobs_held[v][ring_tail[v]];
                    ring_tail[v] = ring_tail[v] - idx_t'(1);
                    a.from_core = v[CORE_W-1:0];
                    a.stolen = 1'b1;
                    found = 1'b1;
                end
            end
            if (found)
                jobs_taken[c] = jobs_taken[c] + TAKEN_W'(1);
            else
                a.status = ST_EMPTY;
        end
        a.queue_count = ring_tail[c] - ring_head[c];
        a.taken_count = jobs_taken[c];
        return a;
    endfunction

    function automatic int draw_idle(int n, int period);
        if ((n % period) < period / 3)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    function automatic logic [1:0] push_mode();
        return $urandom_range(0, 1) ? MODE_ENQ_FRONT : MODE_ENQ_BACK;
    endfunction

    function automatic logic [1:0] take_mode();
        return $urandom_range(0, 3) == 0 ? MODE_TAKE_ALT : MODE_TAKE;
    endfunction

    task automatic add_request(input logic [1:0] mode, input int core,
                               input logic [PID_W-1:0] pid,
                               input logic [WEIGHT_W-1:0] weight, input bit wait_idle);
        request_item_t item;
        item.r.mode       = mode;
        item.r.core       = core[CORE_W-1:0];
        item.r.new_pid    = pid;
        item.r.new_weight = weight;
        item.wait_idle    = wait_idle;
        request_queue.insert(request_queue.size(), item);
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            req_gap   <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                expected_answers.insert(expected_answers.size(), schedule_step(req));
                requests_sent = requests_sent + 1;
            end
            if (!req_valid || req_ready)
            begin
                if (req_gap != 0)
                begin
                    req_gap   <= req_gap - 1;
                    req_valid <= 1'b0;
                end
                else if (request_queue.size() != 0 &&
                         !(request_queue[0].wait_idle && expected_answers.size() != 0))
                begin
                    req       <= request_queue[0].r;
                    req_valid <= 1'b1;
                    req_gap   <= draw_idle(requests_sent, 120);
                    request_queue.delete(0);
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // answer monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            rsp_stall <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    $display("%0t ns: answer with no request pending, got %0h", $time, rsp);
                    mismatches++;
                end
                else
                begin
                    compare_field("status", expected_answers[0].status, rsp.status);
                    compare_field("job_pid", expected_answers[0].job_pid, rsp.job_pid);
                    compare_field("job_weight", expected_answers[0].job_weight,
                                  rsp.job_weight);
                    compare_field("from_core", expected_answers[0].from_core, rsp.from_core);
                    compare_field("stolen", expected_answers[0].stolen, rsp.stolen);
                    compare_field("queue_count", expected_answers[0].queue_count,
                                  rsp.queue_count);
                    compare_field("taken_count", expected_answers[0].taken_count,
                                  rsp.taken_count);
                    expected_answers.delete(0);
                end
                // long hold-off so the block backs up into its request side
                if (answers_seen == 250 || answers_seen == 600)
                    rsp_pause = 90;
                else
                    rsp_pause = draw_idle(answers_seen, 150);
                answers_seen = answers_seen + 1;
                rsp_stall <= rsp_pause;
                rsp_ready <= (rsp_pause == 0);
            end
            else if (rsp_stall != 0)
            begin
                rsp_stall <= rsp_stall - 1;
                rsp_ready <= (rsp_stall == 1);
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int k;
        int n;
        int kind;
        int c;
        for (k = 0; k < CORES; k++)
        begin
            ring_head[k]  = '0;
            ring_tail[k]  = '0;
            jobs_taken[k] = '0;
        end

        // directed: empty take, both pushes, own take, mode three, steals, field extremes
        add_request(MODE_TAKE, 0, 16'hFFFF, 8'hFF, 1'b0);
        add_request(MODE_ENQ_BACK, 0, 16'hFFFF, 8'hFF, 1'b0);
        add_request(MODE_ENQ_FRONT, 0, 16'h0000, 8'h00, 1'b0);
        add_request(MODE_ENQ_BACK, 1, 16'h8001, 8'h80, 1'b0);
        add_request(MODE_ENQ_FRONT, 3, 16'h7FFE, 8'h7F, 1'b0);
        add_request(MODE_ENQ_BACK, 3, 16'h1234, 8'h5A, 1'b0);
        add_request(MODE_ENQ_BACK, 2, 16'hA5A5, 8'hC3, 1'b0);
        add_request(MODE_TAKE, 0, 16'h0000, 8'h00, 1'b0);
        add_request(MODE_TAKE_ALT, 0, 16'hFFFF, 8'hFF, 1'b0);
        add_request(MODE_TAKE, 0, 16'h5555, 8'hAA, 1'b0);
        add_request(MODE_TAKE, 1, 16'hAAAA, 8'h55, 1'b0);
        add_request(MODE_TAKE, 2, 16'h0F0F, 8'hF0, 1'b0);
        add_request(MODE_TAKE, 3, 16'hF0F0, 8'h0F, 1'b0);
        add_request(MODE_TAKE, 3, 16'h0001, 8'h01, 1'b0);
        add_request(MODE_TAKE_ALT, 2, 16'h8000, 8'h80, 1'b0);
        add_request(MODE_TAKE, 1, 16'h0000, 8'h00, 1'b0);

        // fill one ring past full, then drain it with own takes and steals
        c = $urandom_range(0, CORES - 1);
        for (k = 0; k < DEPTH + 3; k++)
            add_request(push_mode(), c, 16'($urandom), 8'($urandom), k == 0);
        for (k = 0; k < DEPTH + 3; k++)
            add_request(take_mode(), $urandom_range(0, CORES - 1), 16'($urandom),
                        8'($urandom), 1'b0);

        while (request_queue.size() < 820)
        begin
            kind = $urandom_range(0, 9);
            n = $urandom_range(1, 12);
            c = $urandom_range(0, CORES - 1);
            for (k = 0; k < n; k++)
            begin
                if (kind < 5)
                    add_request(k < n / 2 ? push_mode() : take_mode(),
                                $urandom_range(0, CORES - 1), 16'($urandom), 8'($urandom),
                                k == 0 && $urandom_range(0, 14) == 0);
                else if (kind < 8)
                    add_request(k < n / 2 ? push_mode() : take_mode(),
                                k < n / 2 ? c : (c + $urandom_range(1, CORES - 1)) % CORES,
                                16'($urandom), 8'($urandom), 1'b0);
                else
                    add_request(2'($urandom), $urandom_range(0, CORES - 1), 16'($urandom),
                                8'($urandom), 1'b0);
            end
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (request_queue.size() != 0 || req_valid || expected_answers.size() != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
